/* hdl/scfb_pkg.sv */
// scfb_pkg: shared types, constants and the crc byte step for the speed command framer
// no dependencies; used by every module of the block by scoped names

package scfb_pkg;

    localparam int unsigned FRAME_BYTES = 17;
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(15);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] FRAME_LEN = 16'(FRAME_BYTES);

    // request queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_ID       = CFG_IDX_W'(3);

    typedef struct packed {
        logic [15:0] right_speed;
        logic [15:0] left_speed;
        logic [31:0] command_word;
    } request_t;

    typedef struct packed {
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [7:0]  device_address;
        logic [15:0] board_id;
    } cfg_regs_t;

    // queue head towards the back end
    typedef struct packed {
        logic     valid;
        request_t req;
    } queue_head_t;

    // one byte through crc-16/ccitt-false, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/scfb_front.sv */
// scfb_front: accepts requests from the input stream into a short queue
// depends on scfb_pkg

module scfb_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // command_word[31:0], left_speed[47:32], right_speed[63:48]
    output scfb_pkg::queue_head_t head,
    input  logic                  pop
);

    scfb_pkg::request_t                slots_reg [scfb_pkg::QUEUE_DEPTH];
    logic [scfb_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [scfb_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [scfb_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              push;

    assign s_tready = (count_reg != scfb_pkg::QCNT_W'(scfb_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;

    assign head.valid = (count_reg != '0);
    assign head.req   = slots_reg[rd_ptr_reg];

    function automatic logic [scfb_pkg::QPTR_W-1:0] ptr_inc(input logic [scfb_pkg::QPTR_W-1:0] p);
        if (p == scfb_pkg::QPTR_W'(scfb_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= s_tdata;
        end
    end

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= scfb_pkg::QCNT_W'(scfb_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_head_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        head.valid && !pop |=> head.valid && $stable(head.req))
        else $error("queue head changed while waiting");

endmodule

/* hdl/scfb_back.sv */
// scfb_back: serialises one request into a 17-byte frame with running crc
// depends on scfb_pkg; drives the registered output stream

module scfb_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  scfb_pkg::queue_head_t head,
    output logic                  pop,
    input  scfb_pkg::cfg_regs_t   cfg,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // frame_byte[7:0]
    output logic                  m_tlast    // frame_end
);

    logic                          busy_reg, busy_next;
    logic [scfb_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [15:0]                   crc_reg, crc_next;
    scfb_pkg::request_t            held_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_byte_reg;
    logic                          out_last_reg;
    logic [7:0]                    cur_byte;
    logic                          advance;
    logic                          at_last;

    assign advance = busy_reg && (!out_valid_reg || m_tready);
    assign at_last = (pos_reg == scfb_pkg::POS_LAST);
    assign pop     = head.valid && (!busy_reg || (advance && at_last));

    always_comb begin
        unique case (pos_reg)
            5'd0:    cur_byte = cfg.header_first;
            5'd1:    cur_byte = cfg.header_second;
            5'd2:    cur_byte = scfb_pkg::FRAME_LEN[15:8];
            5'd3:    cur_byte = scfb_pkg::FRAME_LEN[7:0];
            5'd4:    cur_byte = cfg.device_address;
            5'd5:    cur_byte = cfg.board_id[15:8];
            5'd6:    cur_byte = cfg.board_id[7:0];
            5'd7:    cur_byte = held_reg.command_word[31:24];
            5'd8:    cur_byte = held_reg.command_word[23:16];
            5'd9:    cur_byte = held_reg.command_word[15:8];
            5'd10:   cur_byte = held_reg.command_word[7:0];
            5'd11:   cur_byte = held_reg.left_speed[7:0];
            5'd12:   cur_byte = held_reg.left_speed[15:8];
            5'd13:   cur_byte = held_reg.right_speed[7:0];
            5'd14:   cur_byte = held_reg.right_speed[15:8];
            5'd15:   cur_byte = crc_reg[15:8];
            5'd16:   cur_byte = crc_reg[7:0];
            default: cur_byte = 8'h00;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        if (advance) begin
            if (at_last) begin
                busy_next = 1'b0;
                pos_next  = '0;
                crc_next  = scfb_pkg::CRC_INIT;
            end else begin
                pos_next = pos_reg + 1'b1;
                // header and body bytes feed the crc, its own two bytes do not
                if (pos_reg < scfb_pkg::POS_CRC_HI) begin
                    crc_next = scfb_pkg::crc_feed(crc_reg, cur_byte);
                end
            end
        end
        if (pop) begin
            busy_next = 1'b1;
            pos_next  = '0;
            crc_next  = scfb_pkg::CRC_INIT;
        end
        out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            crc_reg       <= scfb_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            held_reg <= head.req;
        end
        if (advance) begin
            out_byte_reg <= cur_byte;
            out_last_reg <= at_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= scfb_pkg::POS_LAST)
        else $error("byte position past end of frame");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (pos_reg == '0) && (crc_reg == scfb_pkg::CRC_INIT))
        else $error("idle serialiser holds stale position or crc");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_tlast == $past(at_last)) && m_tvalid)
        else $error("frame end flag out of step with byte position");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_tvalid && !m_tready |=> $stable(pos_reg) && $stable(crc_reg))
        else $error("serialiser moved on while output stalled");

endmodule

/* hdl/speed_command_frame_builder.sv */
// speed_command_frame_builder: top level, configuration registers and stream ports
// depends on scfb_pkg, scfb_front and scfb_back
//
// usage:
//   s_ stream: one request per beat, tdata = command, left and right speed.
//   m_ stream: 17 beats per request, one frame byte each; tlast on the
//   crc low byte. frame: header bytes, length 17, address, board id,
//   command msb first, speeds low byte first, crc-16/ccitt-false msb first.
//   cfg port: index 0 header_first, 1 header_second, 2 device_address,
//   3 board_id; other indexes are ignored. cfg_ready is always high;
//   write only while no frame is pending.
// path: a request passes the queue slot and the held register, then its bytes the output register.
// throughput: one byte per cycle while m_tready is high; the serialiser
//   loads the next request at the edge that registers the previous frame's
//   last byte, so frames follow without gaps. a two-entry queue takes
//   requests while a frame is still going out.
// reset: synchronous, active low; queue emptied, cfg registers cleared to 0, crc set to ffff.
// stall: a low m_tready holds the byte in the output register and freezes
//   the serialiser; the queue fills and then s_tready drops.

module speed_command_frame_builder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // command_word[31:0], left_speed[47:32], right_speed[63:48]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // frame_byte[7:0]
    output logic                            m_tlast,   // frame_end
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scfb_pkg::CFG_DATA_W-1:0] cfg_data
);

    scfb_pkg::cfg_regs_t   cfg_reg;
    scfb_pkg::cfg_regs_t   cfg_next;
    scfb_pkg::queue_head_t head;
    logic                  pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                scfb_pkg::CFG_HEADER_FIRST:   cfg_next.header_first   = cfg_data[7:0];
                scfb_pkg::CFG_HEADER_SECOND:  cfg_next.header_second  = cfg_data[7:0];
                scfb_pkg::CFG_DEVICE_ADDRESS: cfg_next.device_address = cfg_data[7:0];
                scfb_pkg::CFG_BOARD_ID:       cfg_next.board_id       = cfg_data[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    scfb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    scfb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
